>>> design/nearest_zone_search_unit_macros.svh
// Assertion macros shared by the nearest zone search design.
`ifndef NEAREST_ZONE_SEARCH_UNIT_MACROS_SVH
`define NEAREST_ZONE_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NZS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define NZS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/nzs_pkg.sv
// Types, constants and codes for the nearest zone search unit.
package nzs_pkg;

   localparam int MAX_ZONES_DEF = 512;
   localparam int MAX_EXTRA_DEF = 16;

   localparam int LAT_W    = 14;
   localparam int LON_W    = 15;
   localparam int ZONE_W   = 9;
   localparam int ACT_W    = 2;
   localparam int KIND_W   = 2;
   localparam int DIST_W   = 15;
   localparam int SUM_W    = 16;   // internal distance, holds every exact sum
   localparam int OCNT_W   = 10;
   localparam int XCNT_W   = 5;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;
   localparam int POS_W    = LAT_W + LON_W;
   localparam int XPOS_W   = ZONE_W + POS_W;

   // 360 degrees in arc-minutes
   localparam logic [16:0] WRAP_MIN = 17'd21600;

   typedef enum logic [ACT_W-1:0] {
      ACT_LOAD_OFFICIAL = 2'd0,
      ACT_LOAD_EXTRA    = 2'd1,
      ACT_QUERY         = 2'd2,
      ACT_NONE          = 2'd3
   } nzs_action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_OFFICIAL = 2'd0,
      KIND_EXTRA    = 2'd1,
      KIND_DEFAULT  = 2'd2
   } nzs_kind_type;

   typedef enum logic [1:0] {
      REG_OFFICIAL_COUNT = 2'd0,
      REG_EXTRA_COUNT    = 2'd1,
      REG_DEFAULT_ZONE   = 2'd2,
      REG_UNUSED         = 2'd3
   } nzs_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OSCAN,
      ST_XSCAN,
      ST_DRAIN,
      ST_DONE
   } nzs_state_type;

endpackage

>>> design/nearest_zone_search_unit.sv
// Nearest zone search unit: table memories, scan sequencer and distance pipeline.
//
// Input channel req_*: one transaction per item. A load (official or extra)
// writes one table slot and gives no result; slots beyond a table's depth are
// dropped. A query scans official entries 0..N-1 and then extra entries
// 0..M-1 (N, M from the count registers, saturated at the table depths) and
// returns one rsp_* transaction with the closest zone.
// A query issues one memory read per cycle from the single read port of each
// table, followed by a three-stage distance/compare pipeline. With N = 0 the
// scan is skipped and the default zone is returned with distance zero.
// Only one query is in flight; req_ready is high whenever the sequencer is
// idle, including while a finished result waits in the output register.
// If the receiver stalls, a finished query waits until the output register
// frees up, and no new transaction is taken meanwhile.
// csr_*: APB-style port, registers at 0x0 official_count, 0x4 extra_count,
// 0x8 default_zone; the user writes them only while idle; the unit does not check.
// Reset (synchronous) clears the registers, the sequencer and the output;
// the tables are not cleared and must be loaded before they are scanned.
`include "nearest_zone_search_unit_macros.svh"

module nearest_zone_search_unit #(
   parameter int MAX_ZONES = nzs_pkg::MAX_ZONES_DEF,
   parameter int MAX_EXTRA = nzs_pkg::MAX_EXTRA_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [nzs_pkg::ACT_W-1:0]         req_action,
   input  logic [nzs_pkg::ZONE_W-1:0]        req_entry_index,
   input  logic signed [nzs_pkg::LAT_W-1:0]  req_latitude_min,
   input  logic signed [nzs_pkg::LON_W-1:0]  req_longitude_min,
   input  logic [nzs_pkg::ZONE_W-1:0]        req_linked_zone,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [nzs_pkg::ZONE_W-1:0]        rsp_zone_index,
   output logic [nzs_pkg::KIND_W-1:0]        rsp_match_kind,
   output logic [nzs_pkg::DIST_W-1:0]        rsp_best_distance,

   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [nzs_pkg::CSR_AW-1:0]        paddr,
   input  logic [nzs_pkg::CSR_DW-1:0]        pwdata,
   output logic [nzs_pkg::CSR_DW-1:0]        prdata,
   output logic                              pready
);

   localparam int ZW   = $clog2(MAX_ZONES);
   localparam int XW   = (MAX_EXTRA > 1) ? $clog2(MAX_EXTRA) : 1;
   localparam int OC_W = ($clog2(MAX_ZONES + 1) > nzs_pkg::OCNT_W) ?
                         $clog2(MAX_ZONES + 1) : nzs_pkg::OCNT_W;
   localparam int XC_W = ($clog2(MAX_EXTRA + 1) > nzs_pkg::XCNT_W) ?
                         $clog2(MAX_EXTRA + 1) : nzs_pkg::XCNT_W;
   localparam int IW   = (ZW > nzs_pkg::ZONE_W) ? ZW : nzs_pkg::ZONE_W;

   localparam int LAT_W = nzs_pkg::LAT_W;
   localparam int LON_W = nzs_pkg::LON_W;
   localparam int SUM_W = nzs_pkg::SUM_W;

   // ---------------- configuration registers ----------------
   logic [nzs_pkg::OCNT_W-1:0] ocount_ff, ocount_in;
   logic [nzs_pkg::XCNT_W-1:0] xcount_ff, xcount_in;
   logic [nzs_pkg::ZONE_W-1:0] dzone_ff, dzone_in;
   logic                       csr_wr;
   nzs_pkg::nzs_reg_type       csr_reg;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign csr_reg = nzs_pkg::nzs_reg_type'(paddr[3:2]);

   always_comb begin
      ocount_in = ocount_ff;
      xcount_in = xcount_ff;
      dzone_in  = dzone_ff;
      if (csr_wr) begin
         unique case (csr_reg)
            nzs_pkg::REG_OFFICIAL_COUNT: ocount_in = pwdata[nzs_pkg::OCNT_W-1:0];
            nzs_pkg::REG_EXTRA_COUNT:    xcount_in = pwdata[nzs_pkg::XCNT_W-1:0];
            nzs_pkg::REG_DEFAULT_ZONE:   dzone_in  = pwdata[nzs_pkg::ZONE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         nzs_pkg::REG_OFFICIAL_COUNT: prdata = nzs_pkg::CSR_DW'(ocount_ff);
         nzs_pkg::REG_EXTRA_COUNT:    prdata = nzs_pkg::CSR_DW'(xcount_ff);
         nzs_pkg::REG_DEFAULT_ZONE:   prdata = nzs_pkg::CSR_DW'(dzone_ff);
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ocount_ff <= '0;
         xcount_ff <= '0;
         dzone_ff  <= '0;
      end else begin
         ocount_ff <= ocount_in;
         xcount_ff <= xcount_in;
         dzone_ff  <= dzone_in;
      end
   end

   // saturated scan lengths
   logic [OC_W-1:0] ocnt_ext, n_off;
   logic [XC_W-1:0] xcnt_ext, n_ext;

   assign ocnt_ext = OC_W'(ocount_ff);
   assign xcnt_ext = XC_W'(xcount_ff);
   assign n_off    = (ocnt_ext > OC_W'(MAX_ZONES)) ? OC_W'(MAX_ZONES) : ocnt_ext;
   assign n_ext    = (xcnt_ext > XC_W'(MAX_EXTRA)) ? XC_W'(MAX_EXTRA) : xcnt_ext;

   // ---------------- table memories ----------------
   logic [nzs_pkg::POS_W-1:0]  off_mem [MAX_ZONES];
   logic [nzs_pkg::XPOS_W-1:0] ext_mem [MAX_EXTRA];
   logic [nzs_pkg::POS_W-1:0]  off_rdata_ff;
   logic [nzs_pkg::XPOS_W-1:0] ext_rdata_ff;
   logic                       wr_off_en, wr_ext_en, rd_off_en, rd_ext_en;
   logic [IW-1:0]              idx_ext;
   logic [OC_W-1:0]            cnt_ff, cnt_in;
   logic [XC_W-1:0]            xcnt_ff, xcnt_in;

   assign idx_ext = IW'(req_entry_index);

   always_ff @(posedge clock) begin
      if (wr_off_en)
         off_mem[idx_ext[ZW-1:0]] <= {req_latitude_min, req_longitude_min};
      if (rd_off_en)
         off_rdata_ff <= off_mem[cnt_ff[ZW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_ext_en)
         ext_mem[req_entry_index[XW-1:0]] <=
            {req_linked_zone, req_latitude_min, req_longitude_min};
      if (rd_ext_en)
         ext_rdata_ff <= ext_mem[xcnt_ff[XW-1:0]];
   end

   // ---------------- distance pipeline ----------------
   logic                          rd_v_ff, rd_v_in;
   nzs_pkg::nzs_kind_type         rd_kind_ff, rd_kind_in;
   logic [nzs_pkg::ZONE_W-1:0]    rd_zone_ff, rd_zone_in;
   logic signed [LAT_W-1:0]       q_lat_ff, q_lat_in;
   logic signed [LON_W-1:0]       q_lon_ff, q_lon_in;

   logic signed [LAT_W-1:0]       e_lat;
   logic signed [LON_W-1:0]       e_lon, lon_w, lon_e;
   logic [LAT_W:0]                dlat;
   logic [16:0]                   alt_raw;

   logic                          s1_v_ff;
   nzs_pkg::nzs_kind_type         s1_kind_ff, s1_kind_in;
   logic [nzs_pkg::ZONE_W-1:0]    s1_zone_ff, s1_zone_in;
   logic [LAT_W:0]                s1_alat_ff, s1_alat_in;
   logic [SUM_W-1:0]              s1_span_ff, s1_span_in;
   logic [SUM_W-1:0]              s1_alt_ff, s1_alt_in;
   logic                          s1_wrap_ff, s1_wrap_in;

   logic                          s2_v_ff;
   nzs_pkg::nzs_kind_type         s2_kind_ff;
   logic [nzs_pkg::ZONE_W-1:0]    s2_zone_ff;
   logic [SUM_W-1:0]              s2_dist_ff, s2_dist_in, dlon;

   // stage 1: latitude difference, longitude span and wrapped span
   always_comb begin
      if (rd_kind_ff == nzs_pkg::KIND_EXTRA) begin
         e_lat      = ext_rdata_ff[nzs_pkg::POS_W-1:LON_W];
         e_lon      = ext_rdata_ff[LON_W-1:0];
         s1_zone_in = ext_rdata_ff[nzs_pkg::XPOS_W-1:nzs_pkg::POS_W];
      end else begin
         e_lat      = off_rdata_ff[nzs_pkg::POS_W-1:LON_W];
         e_lon      = off_rdata_ff[LON_W-1:0];
         s1_zone_in = rd_zone_ff;
      end
      s1_kind_in = rd_kind_ff;
      dlat       = {e_lat[LAT_W-1], e_lat} - {q_lat_ff[LAT_W-1], q_lat_ff};
      s1_alat_in = dlat[LAT_W] ? (~dlat + 15'd1) : dlat;
      if (e_lon < q_lon_ff) begin
         lon_w = e_lon;
         lon_e = q_lon_ff;
      end else begin
         lon_w = q_lon_ff;
         lon_e = e_lon;
      end
      s1_span_in = {lon_e[LON_W-1], lon_e} - {lon_w[LON_W-1], lon_w};
      alt_raw    = nzs_pkg::WRAP_MIN + {{2{lon_w[LON_W-1]}}, lon_w}
                   - {{2{lon_e[LON_W-1]}}, lon_e};
      s1_alt_in  = alt_raw[16] ? 16'(~alt_raw + 17'd1) : alt_raw[15:0];
      // wrapping only counts when the two longitudes lie on opposite sides
      s1_wrap_in = lon_w[LON_W-1] & ~lon_e[LON_W-1];
   end

   // stage 2: pick the shorter longitude path, add latitude part
   assign dlon       = (s1_wrap_ff && (s1_alt_ff < s1_span_ff)) ? s1_alt_ff : s1_span_ff;
   assign s2_dist_in = SUM_W'(s1_alat_ff) + dlon;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= rd_v_in;
         s1_v_ff <= rd_v_ff;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_kind_ff <= rd_kind_in;
      rd_zone_ff <= rd_zone_in;
      q_lat_ff   <= q_lat_in;
      q_lon_ff   <= q_lon_in;
      s1_kind_ff <= s1_kind_in;
      s1_zone_ff <= s1_zone_in;
      s1_alat_ff <= s1_alat_in;
      s1_span_ff <= s1_span_in;
      s1_alt_ff  <= s1_alt_in;
      s1_wrap_ff <= s1_wrap_in;
      s2_kind_ff <= s1_kind_ff;
      s2_zone_ff <= s1_zone_ff;
      s2_dist_ff <= s2_dist_in;
   end

   // ---------------- sequencer ----------------
   nzs_pkg::nzs_state_type     state_ff, state_in;
   logic [SUM_W-1:0]           best_ff, best_in;
   logic [nzs_pkg::ZONE_W-1:0] best_zone_ff, best_zone_in;
   nzs_pkg::nzs_kind_type      best_kind_ff, best_kind_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [nzs_pkg::ZONE_W-1:0] rsp_zone_ff, rsp_zone_in;
   nzs_pkg::nzs_kind_type      rsp_kind_ff, rsp_kind_in;
   logic [nzs_pkg::DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic                       req_acc, better;
   nzs_pkg::nzs_action_type    act;

   assign req_ready = (state_ff == nzs_pkg::ST_IDLE);
   assign req_acc   = req_valid & req_ready;
   assign act       = nzs_pkg::nzs_action_type'(req_action);
   assign better    = s2_v_ff && (s2_dist_ff < best_ff);

   assign wr_off_en = req_acc && (act == nzs_pkg::ACT_LOAD_OFFICIAL)
                      && (int'(req_entry_index) < MAX_ZONES);
   assign wr_ext_en = req_acc && (act == nzs_pkg::ACT_LOAD_EXTRA)
                      && (int'(req_entry_index) < MAX_EXTRA);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      xcnt_in      = xcnt_ff;
      q_lat_in     = q_lat_ff;
      q_lon_in     = q_lon_ff;
      rd_off_en    = 1'b0;
      rd_ext_en    = 1'b0;
      rd_kind_in   = rd_kind_ff;
      rd_zone_in   = cnt_ff[nzs_pkg::ZONE_W-1:0];
      best_in      = best_ff;
      best_zone_in = best_zone_ff;
      best_kind_in = best_kind_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_zone_in  = rsp_zone_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_dist_in  = rsp_dist_ff;

      if (better) begin
         best_in      = s2_dist_ff;
         best_zone_in = s2_zone_ff;
         best_kind_in = s2_kind_ff;
      end

      unique case (state_ff)
         nzs_pkg::ST_IDLE: begin
            if (req_acc && (act == nzs_pkg::ACT_QUERY)) begin
               q_lat_in = req_latitude_min;
               q_lon_in = req_longitude_min;
               cnt_in   = '0;
               xcnt_in  = '0;
               if (n_off == '0) begin
                  best_in      = '0;
                  best_zone_in = dzone_ff;
                  best_kind_in = nzs_pkg::KIND_DEFAULT;
                  state_in     = nzs_pkg::ST_DONE;
               end else begin
                  // all ones exceeds any reachable distance
                  best_in      = '1;
                  best_zone_in = '0;
                  best_kind_in = nzs_pkg::KIND_OFFICIAL;
                  state_in     = nzs_pkg::ST_OSCAN;
               end
            end
         end
         nzs_pkg::ST_OSCAN: begin
            rd_off_en  = 1'b1;
            rd_kind_in = nzs_pkg::KIND_OFFICIAL;
            if (cnt_ff == n_off - OC_W'(1)) begin
               state_in = (n_ext == '0) ? nzs_pkg::ST_DRAIN : nzs_pkg::ST_XSCAN;
            end else begin
               cnt_in = cnt_ff + OC_W'(1);
            end
         end
         nzs_pkg::ST_XSCAN: begin
            rd_ext_en  = 1'b1;
            rd_kind_in = nzs_pkg::KIND_EXTRA;
            if (xcnt_ff == n_ext - XC_W'(1)) begin
               state_in = nzs_pkg::ST_DRAIN;
            end else begin
               xcnt_in = xcnt_ff + XC_W'(1);
            end
         end
         nzs_pkg::ST_DRAIN: begin
            if (!rd_v_ff && !s1_v_ff && !s2_v_ff)
               state_in = nzs_pkg::ST_DONE;
         end
         nzs_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_zone_in  = best_zone_ff;
               rsp_kind_in  = best_kind_ff;
               rsp_dist_in  = best_ff[SUM_W-1] ? '1 : best_ff[nzs_pkg::DIST_W-1:0];
               state_in     = nzs_pkg::ST_IDLE;
            end
         end
         default: state_in = nzs_pkg::ST_IDLE;
      endcase
   end

   assign rd_v_in = rd_off_en | rd_ext_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nzs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      xcnt_ff      <= xcnt_in;
      best_ff      <= best_in;
      best_zone_ff <= best_zone_in;
      best_kind_ff <= best_kind_in;
      rsp_zone_ff  <= rsp_zone_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_dist_ff  <= rsp_dist_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_zone_index    = rsp_zone_ff;
   assign rsp_match_kind    = rsp_kind_ff;
   assign rsp_best_distance = rsp_dist_ff;

   // ---------------- assertions ----------------
   `NZS_ASSERT_NOW(a_pipe_busy, clock, reset,
      (rd_v_ff || s1_v_ff || s2_v_ff),
      (state_ff == nzs_pkg::ST_OSCAN || state_ff == nzs_pkg::ST_XSCAN ||
       state_ff == nzs_pkg::ST_DRAIN),
      "distance pipeline active outside a scan")
   `NZS_ASSERT_NOW(a_done_empty, clock, reset,
      (state_ff == nzs_pkg::ST_DONE),
      (!rd_v_ff && !s1_v_ff && !s2_v_ff),
      "result taken before the pipeline drained")
   `NZS_ASSERT_NEXT(a_query_start, clock, reset,
      (req_acc && act == nzs_pkg::ACT_QUERY && n_off != '0),
      (state_ff == nzs_pkg::ST_OSCAN && cnt_ff == '0),
      "query did not start the official scan")
   `NZS_ASSERT_NOW(a_default_zero, clock, reset,
      ($rose(rsp_valid_ff) && rsp_kind_ff == nzs_pkg::KIND_DEFAULT),
      (rsp_dist_ff == '0),
      "default result with nonzero distance")

endmodule

>>> tb/sv/testbench.sv
// Testbench for the nearest zone search unit: directed table, random phases, scoreboard.
`timescale 1ns / 100ps

module testbench;

   localparam int ACT_W         = nzs_pkg::ACT_W;
   localparam int KIND_W        = nzs_pkg::KIND_W;
   localparam int ZONE_W        = nzs_pkg::ZONE_W;
   localparam int DIST_W        = nzs_pkg::DIST_W;
   localparam int LAT_W         = nzs_pkg::LAT_W;
   localparam int LON_W         = nzs_pkg::LON_W;
   localparam int OCNT_W        = nzs_pkg::OCNT_W;
   localparam int XCNT_W        = nzs_pkg::XCNT_W;
   localparam int CSR_AW        = nzs_pkg::CSR_AW;
   localparam int CSR_DW        = nzs_pkg::CSR_DW;
   localparam int MAX_ZONES_DEF = nzs_pkg::MAX_ZONES_DEF;
   localparam int MAX_EXTRA_DEF = nzs_pkg::MAX_EXTRA_DEF;
   localparam int XTR_IW        = $clog2(MAX_EXTRA_DEF);

   localparam int CLK_HALF      = 4;
   localparam int RESET_CYCLES  = 4;
   localparam int SETTLE_CYCLES = 16;
   localparam int STALL_LIMIT   = 20000;
   localparam int FULL_TURN_MIN = 21600;
   localparam int NO_MATCH_DIST = 60000000;
   localparam int DIST_SAT      = 32767;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [ZONE_W-1:0]     zone;
      nzs_pkg::nzs_kind_type kind;
      logic [DIST_W-1:0]     best_dist;
   } zone_result_type;

   typedef enum bit { ROW_ITEM, ROW_CSR } row_op_type;

   typedef struct packed {
      row_op_type              op;
      nzs_pkg::nzs_action_type act;
      logic [ZONE_W-1:0]       idx;
      int                      lat;
      int                      lon;
      logic [ZONE_W-1:0]       link;
      bit                      lit;
      zone_result_type         want;
      nzs_pkg::nzs_reg_type    creg;
      int                      cval;
   } directed_row_type;

   typedef struct packed {
      logic [OCNT_W-1:0] off;
      logic [XCNT_W-1:0] ext;
      logic [ZONE_W-1:0] def;
      int                send_pct;
      int                recv_pct;
      int                items;
      int                hold;
   } phase_type;

   localparam zone_result_type NIL_RESULT = '{9'd0, nzs_pkg::KIND_OFFICIAL, 15'd0};
   localparam zone_result_type DEF_ZERO   = '{9'd0, nzs_pkg::KIND_DEFAULT, 15'd0};

   localparam int DIR_ROWS = 24;
   localparam directed_row_type DIRECTED [DIR_ROWS] = '{
      // empty table after reset: default zone
      '{ROW_ITEM, nzs_pkg::ACT_QUERY, 9'd0, 5400, 10800, 9'd0, 1'b1, DEF_ZERO,
        nzs_pkg::REG_UNUSED, 0},
      '{ROW_ITEM, nzs_pkg::ACT_QUERY, 9'd0, -5400, -10800, 9'd0, 1'b1, DEF_ZERO,
        nzs_pkg::REG_UNUSED, 0},
      '{ROW_ITEM, nzs_pkg::ACT_LOAD_OFFICIAL, 9'd0, 0, 0, 9'd0, 1'b0, NIL_RESULT,
        nzs_pkg::REG_UNUSED, 0},
      '{ROW_ITEM, nzs_pkg::ACT_LOAD_OFFICIAL, 9'd1, 5400, 10800, 9'd0, 1'b0, NIL_RESULT,
        nzs_pkg::REG_UNUSED, 0},
      '{ROW_ITEM, nzs_pkg::ACT_LOAD_OFFICIAL, 9'd2, -5400, -10800, 9'h1ff, 1'b0, NIL_RESULT,
        nzs_pkg::REG_UNUSED, 0},
      '{ROW_ITEM, nzs_pkg::ACT_LOAD_OFFICIAL, 9'd3, -8192, 16383, 9'd0, 1'b0, NIL_RESULT,
        nzs_pkg::REG_UNUSED, 0},
      '{ROW_ITEM, nzs_pkg::ACT_LOAD_EXTRA, 9'd0, 100, -10790, 9'd511, 1'b0, NIL_RESULT,
        nzs_pkg::REG_UNUSED, 0},
      '{ROW_ITEM, nzs_pkg::ACT_LOAD_EXTRA, 9'd1, 8191, -16384, 9'd0, 1'b0, NIL_RESULT,
        nzs_pkg::REG_UNUSED, 0},
      // slot beyond the extra table and the unused action: both dropped
      '{ROW_ITEM, nzs_pkg::ACT_LOAD_EXTRA, 9'd511, 0, 0, 9'd5, 1'b0, NIL_RESULT,
        nzs_pkg::REG_UNUSED, 0},
      '{ROW_ITEM, nzs_pkg::ACT_NONE, 9'd511, 8191, -16384, 9'd511, 1'b0, NIL_RESULT,
        nzs_pkg::REG_UNUSED, 0},
      '{ROW_ITEM, nzs_pkg::ACT_QUERY, 9'd0, 0, 0, 9'd0, 1'b1, DEF_ZERO,
        nzs_pkg::REG_UNUSED, 0},
      '{ROW_CSR, nzs_pkg::ACT_NONE, 9'd0, 0, 0, 9'd0, 1'b0, NIL_RESULT,
        nzs_pkg::REG_DEFAULT_ZONE, 511},
      '{ROW_ITEM, nzs_pkg::ACT_QUERY, 9'd0, 0, 0, 9'd0, 1'b1,
        '{9'd511, nzs_pkg::KIND_DEFAULT, 15'd0}, nzs_pkg::REG_UNUSED, 0},
      '{ROW_CSR, nzs_pkg::ACT_NONE, 9'd0, 0, 0, 9'd0, 1'b0, NIL_RESULT,
        nzs_pkg::REG_OFFICIAL_COUNT, 4},
      '{ROW_CSR, nzs_pkg::ACT_NONE, 9'd0, 0, 0, 9'd0, 1'b0, NIL_RESULT,
        nzs_pkg::REG_EXTRA_COUNT, 2},
      '{ROW_ITEM, nzs_pkg::ACT_QUERY, 9'd0, 0, 0, 9'd0, 1'b1,
        '{9'd0, nzs_pkg::KIND_OFFICIAL, 15'd0}, nzs_pkg::REG_UNUSED, 0},
      '{ROW_ITEM, nzs_pkg::ACT_QUERY, 9'd0, 100, -10790, 9'd0, 1'b0, NIL_RESULT,
        nzs_pkg::REG_UNUSED, 0},
      // longitude wrap across the date line
      '{ROW_ITEM, nzs_pkg::ACT_QUERY, 9'd0, 5400, -10800, 9'd0, 1'b0, NIL_RESULT,
        nzs_pkg::REG_UNUSED, 0},
      '{ROW_ITEM, nzs_pkg::ACT_QUERY, 9'd0, -5400, 10800, 9'd0, 1'b0, NIL_RESULT,
        nzs_pkg::REG_UNUSED, 0},
      '{ROW_ITEM, nzs_pkg::ACT_QUERY, 9'd0, 8191, -16384, 9'd0, 1'b0, NIL_RESULT,
        nzs_pkg::REG_UNUSED, 0},
      '{ROW_ITEM, nzs_pkg::ACT_QUERY, 9'd0, -8192, 16383, 9'd0, 1'b0, NIL_RESULT,
        nzs_pkg::REG_UNUSED, 0},
      '{ROW_ITEM, nzs_pkg::ACT_QUERY, 9'd0, 0, 10800, 9'd0, 1'b0, NIL_RESULT,
        nzs_pkg::REG_UNUSED, 0},
      '{ROW_CSR, nzs_pkg::ACT_NONE, 9'd0, 0, 0, 9'd0, 1'b0, NIL_RESULT,
        nzs_pkg::REG_EXTRA_COUNT, 0},
      '{ROW_ITEM, nzs_pkg::ACT_QUERY, 9'd0, 100, -10790, 9'd0, 1'b0, NIL_RESULT,
        nzs_pkg::REG_UNUSED, 0}
   };

   localparam int NUM_PHASES = 8;
   localparam phase_type PHASES [NUM_PHASES] = '{
      '{10'd1,    5'd0,  9'd300, 0,  0,  40,  0},
      '{10'd8,    5'd16, 9'd0,   69, 0,  80,  0},
      '{10'd32,   5'd5,  9'd511, 0,  69, 120, 3000},
      '{10'd0,    5'd31, 9'd511, 11, 11, 60,  0},
      '{10'd64,   5'd31, 9'd128, 11, 11, 120, 0},
      '{10'd1023, 5'd16, 9'd5,   0,  0,  30,  0},
      '{10'd512,  5'd0,  9'd0,   0,  69, 30,  0},
      '{10'd3,    5'd1,  9'd255, 0,  0,  100, 0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [ACT_W-1:0]         req_action = nzs_pkg::ACT_NONE;
   logic [ZONE_W-1:0]        req_entry_index = '0;
   logic signed [LAT_W-1:0]  req_latitude_min = '0;
   logic signed [LON_W-1:0]  req_longitude_min = '0;
   logic [ZONE_W-1:0]        req_linked_zone = '0;

   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [ZONE_W-1:0]        rsp_zone_index;
   logic [KIND_W-1:0]        rsp_match_kind;
   logic [DIST_W-1:0]        rsp_best_distance;

   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_AW-1:0]        paddr = '0;
   logic [CSR_DW-1:0]        pwdata = '0;
   logic [CSR_DW-1:0]        prdata;
   logic                     pready;

   // local copy of the unit's tables and registers
   logic signed [LAT_W-1:0]  off_lat [MAX_ZONES_DEF];
   logic signed [LON_W-1:0]  off_lon [MAX_ZONES_DEF];
   bit                       official_written [MAX_ZONES_DEF];
   logic signed [LAT_W-1:0]  xtr_lat [MAX_EXTRA_DEF];
   logic signed [LON_W-1:0]  xtr_lon [MAX_EXTRA_DEF];
   logic [ZONE_W-1:0]        xtr_link [MAX_EXTRA_DEF];
   bit                       extra_written [MAX_EXTRA_DEF];
   logic [OCNT_W-1:0]        off_cnt = '0;
   logic [XCNT_W-1:0]        ext_cnt = '0;
   logic [ZONE_W-1:0]        def_zone = '0;

   zone_result_type          pending_zones [$];
   bit                       cur_lit = 1'b0;
   zone_result_type          cur_lit_res = NIL_RESULT;
   int                       mismatches = 0;
   int                       idle_cycles = 0;
   int                       send_idle_pct = 0;
   int                       recv_stall_pct = 0;
   bit                       hold_results = 1'b0;

   nearest_zone_search_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_entry_index   (req_entry_index),
      .req_latitude_min  (req_latitude_min),
      .req_longitude_min (req_longitude_min),
      .req_linked_zone   (req_linked_zone),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_zone_index    (rsp_zone_index),
      .rsp_match_kind    (rsp_match_kind),
      .rsp_best_distance (rsp_best_distance),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #CLK_HALF clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= !hold_results && ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic int arc_distance(int la_a, int lo_a, int la_b, int lo_b);
      int w, e, dlon, alt, dlat;
      w = (lo_a < lo_b) ? lo_a : lo_b;
      e = (lo_a < lo_b) ? lo_b : lo_a;
      dlon = e - w;
      // opposite hemispheres: the way round through 180 may be shorter
      if (w < 0 && e >= 0) begin
         alt = FULL_TURN_MIN + w - e;
         if (alt < 0) alt = -alt;
         if (alt < dlon) dlon = alt;
      end
      dlat = la_a - la_b;
      if (dlat < 0) dlat = -dlat;
      return dlat + dlon;
   endfunction

   function automatic zone_result_type nearest_zone(int la, int lo);
      zone_result_type r;
      int n, m, best, d;
      n = (off_cnt > MAX_ZONES_DEF) ? MAX_ZONES_DEF : int'(off_cnt);
      m = (ext_cnt > MAX_EXTRA_DEF) ? MAX_EXTRA_DEF : int'(ext_cnt);
      if (n == 0) begin
         r.zone = def_zone;
         r.kind = nzs_pkg::KIND_DEFAULT;
         r.best_dist = '0;
         return r;
      end
      best = NO_MATCH_DIST;
      r.zone = '0;
      r.kind = nzs_pkg::KIND_OFFICIAL;
      for (int i = 0; i < n; i++) begin
         d = arc_distance(int'(off_lat[i]), int'(off_lon[i]), la, lo);
         if (d < best) begin
            best = d;
            r.zone = ZONE_W'(i);
         end
      end
      // extras must be strictly closer than the best so far
      for (int i = 0; i < m; i++) begin
         d = arc_distance(int'(xtr_lat[i]), int'(xtr_lon[i]), la, lo);
         if (d < best) begin
            best = d;
            r.zone = xtr_link[i];
            r.kind = nzs_pkg::KIND_EXTRA;
         end
      end
      r.best_dist = (best > DIST_SAT) ? DIST_W'(DIST_SAT) : DIST_W'(best);
      return r;
   endfunction

   function automatic int rand_lat();
      int pool [7] = '{-5400, -5399, -1, 0, 1, 5399, 5400};
      case ($urandom_range(9))
         0: return int'($urandom_range(16383)) - 8192;
         1, 2: return pool[$urandom_range(6)];
         default: return int'($urandom_range(10800)) - 5400;
      endcase
   endfunction

   function automatic int rand_lon();
      int pool [9] = '{-10800, -10799, -5400, -1, 0, 1, 5400, 10799, 10800};
      case ($urandom_range(9))
         0: return int'($urandom_range(32767)) - 16384;
         1, 2: return pool[$urandom_range(8)];
         default: return int'($urandom_range(21600)) - 10800;
      endcase
   endfunction

   task automatic flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
   endtask

   // called at a falling edge, returns at the falling edge after the transaction
   task automatic send_item(nzs_pkg::nzs_action_type act, logic [ZONE_W-1:0] idx,
                            int lat, int lon, logic [ZONE_W-1:0] link, bit lit,
                            zone_result_type lit_res);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_action        = act;
      req_entry_index   = idx;
      req_latitude_min  = LAT_W'(lat);
      req_longitude_min = LON_W'(lon);
      req_linked_zone   = link;
      cur_lit           = lit;
      cur_lit_res       = lit_res;
      req_valid         = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_zones.size() != 0) @(negedge clock);
      // settle before moving on; loads and dropped items leave no result to wait for
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(nzs_pkg::nzs_reg_type sel, int value);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {sel, 2'b00};
      pwdata  = CSR_DW'(value);
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      case (sel)
         nzs_pkg::REG_OFFICIAL_COUNT: off_cnt  = value[OCNT_W-1:0];
         nzs_pkg::REG_EXTRA_COUNT:    ext_cnt  = value[XCNT_W-1:0];
         nzs_pkg::REG_DEFAULT_ZONE:   def_zone = value[ZONE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic hold_results_for(int cycles);
      hold_results = 1'b1;
      repeat (cycles) @(negedge clock);
      hold_results = 1'b0;
   endtask

   task automatic send_random_item();
      int pick, n, lat, lon, s;
      pick = $urandom_range(99);
      lat = rand_lat();
      lon = rand_lon();
      n = (off_cnt > MAX_ZONES_DEF) ? MAX_ZONES_DEF : int'(off_cnt);
      if (pick < 55) begin
         // sit on or next to a stored zone to hit ties and zero distances
         if (n > 0 && $urandom_range(99) < 20) begin
            s = $urandom_range(n - 1);
            lat = int'(off_lat[s]) + int'($urandom_range(2)) - 1;
            lon = int'(off_lon[s]) + int'($urandom_range(2)) - 1;
         end
         send_item(nzs_pkg::ACT_QUERY, ZONE_W'($urandom_range(511)), lat, lon,
                   ZONE_W'($urandom_range(511)), 1'b0, NIL_RESULT);
      end else if (pick < 75) begin
         s = $urandom_range(1) ? $urandom_range(511) : $urandom_range((n > 0) ? n - 1 : 0);
         send_item(nzs_pkg::ACT_LOAD_OFFICIAL, ZONE_W'(s), lat, lon,
                   ZONE_W'($urandom_range(511)), 1'b0, NIL_RESULT);
      end else if (pick < 90) begin
         send_item(nzs_pkg::ACT_LOAD_EXTRA, ZONE_W'($urandom_range(MAX_EXTRA_DEF - 1)),
                   lat, lon, ZONE_W'($urandom_range(511)), 1'b0, NIL_RESULT);
      end else if (pick < 95) begin
         send_item(nzs_pkg::ACT_LOAD_EXTRA, ZONE_W'($urandom_range(511, MAX_EXTRA_DEF)),
                   lat, lon, ZONE_W'($urandom_range(511)), 1'b0, NIL_RESULT);
      end else begin
         send_item(nzs_pkg::ACT_NONE, ZONE_W'($urandom_range(511)), lat, lon,
                   ZONE_W'($urandom_range(511)), 1'b0, NIL_RESULT);
      end
   endtask

   task automatic run_phase(phase_type p);
      int need_off, need_ext;
      need_off = (p.off > MAX_ZONES_DEF) ? MAX_ZONES_DEF : int'(p.off);
      need_ext = (p.ext > MAX_EXTRA_DEF) ? MAX_EXTRA_DEF : int'(p.ext);
      // every slot the scan will touch gets written first
      for (int i = 0; i < need_off; i++) begin
         if (!official_written[i])
            send_item(nzs_pkg::ACT_LOAD_OFFICIAL, ZONE_W'(i), rand_lat(), rand_lon(),
                      ZONE_W'($urandom_range(511)), 1'b0, NIL_RESULT);
      end
      for (int i = 0; i < need_ext; i++) begin
         if (!extra_written[i])
            send_item(nzs_pkg::ACT_LOAD_EXTRA, ZONE_W'(i), rand_lat(), rand_lon(),
                      ZONE_W'($urandom_range(511)), 1'b0, NIL_RESULT);
      end
      wait_idle();
      write_csr(nzs_pkg::REG_OFFICIAL_COUNT, int'(p.off));
      write_csr(nzs_pkg::REG_EXTRA_COUNT, int'(p.ext));
      write_csr(nzs_pkg::REG_DEFAULT_ZONE, int'(p.def));
      send_idle_pct  = p.send_pct;
      recv_stall_pct = p.recv_pct;
      if (p.hold > 0) begin
         fork
            hold_results_for(p.hold);
         join_none
      end
      repeat (p.items) send_random_item();
   endtask

   always @(posedge clock) begin : observe
      zone_result_type want;
      logic took;
      if (!reset) begin
         took = 1'b0;
         if (req_valid && req_ready) begin
            took = 1'b1;
            case (req_action)
               nzs_pkg::ACT_LOAD_OFFICIAL: begin
                  off_lat[req_entry_index] = req_latitude_min;
                  off_lon[req_entry_index] = req_longitude_min;
                  official_written[req_entry_index] = 1'b1;
               end
               nzs_pkg::ACT_LOAD_EXTRA: begin
                  if (req_entry_index < MAX_EXTRA_DEF) begin
                     xtr_lat[req_entry_index[XTR_IW-1:0]]  = req_latitude_min;
                     xtr_lon[req_entry_index[XTR_IW-1:0]]  = req_longitude_min;
                     xtr_link[req_entry_index[XTR_IW-1:0]] = req_linked_zone;
                     extra_written[req_entry_index[XTR_IW-1:0]] = 1'b1;
                  end
               end
               nzs_pkg::ACT_QUERY: begin
                  pending_zones.push_back(cur_lit ? cur_lit_res :
                     nearest_zone(int'(req_latitude_min), int'(req_longitude_min)));
               end
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            took = 1'b1;
            if (pending_zones.size() == 0) begin
               flag_mismatch($sformatf("unexpected result zone %0d kind %0d dist %0d",
                  rsp_zone_index, rsp_match_kind, rsp_best_distance));
            end else begin
               want = pending_zones.pop_front();
               if (rsp_zone_index !== want.zone || rsp_match_kind !== want.kind ||
                   rsp_best_distance !== want.best_dist)
                  flag_mismatch($sformatf(
                     "expected zone %0d kind %0d dist %0d, got zone %0d kind %0d dist %0d",
                     want.zone, want.kind, want.best_dist,
                     rsp_zone_index, rsp_match_kind, rsp_best_distance));
            end
         end
         idle_cycles = took ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      for (int r = 0; r < DIR_ROWS; r++) begin
         if (DIRECTED[r].op == ROW_CSR) begin
            wait_idle();
            write_csr(DIRECTED[r].creg, DIRECTED[r].cval);
         end else begin
            send_item(DIRECTED[r].act, DIRECTED[r].idx, DIRECTED[r].lat, DIRECTED[r].lon,
                      DIRECTED[r].link, DIRECTED[r].lit, DIRECTED[r].want);
         end
      end
      for (int p = 0; p < NUM_PHASES; p++) run_phase(PHASES[p]);
      wait_idle();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/nzs_pkg.sv
design/nearest_zone_search_unit.sv
tb/sv/testbench.sv
